// ----- hdl/b64te_pkg.sv -----
package b64te_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 6;
    localparam int CARRY_W     = 4;
    localparam int GROUP_CHARS = 4;
    localparam int SLOT_W      = $clog2(GROUP_CHARS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h2D;

    // one request worth of output characters
    typedef struct packed {
        logic [GROUP_CHARS-1:0][DIGIT_W-1:0] digit;
        logic [GROUP_CHARS-1:0]              pad;
        logic [SLOT_W-1:0]                   last_slot;
        logic                                eot;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        logic [CHAR_W-1:0] ch;
        dx = {1'b0, d};
        if (d < 6'd26)
        begin
            ch = 7'h41 + dx;
        end
        else if (d < 6'd52)
        begin
            ch = 7'h61 + (dx - 7'd26);
        end
        else if (d < 6'd62)
        begin
            ch = 7'h30 + (dx - 7'd52);
        end
        else if (d == 6'd62)
        begin
            ch = 7'h2E;
        end
        else
        begin
            ch = 7'h5F;
        end
        return ch;
    endfunction

endpackage

// ----- hdl/b64te_if.sv -----
interface b64te_byte_if
    import b64te_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64te_char_if
    import b64te_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              end_of_text;

    modport source (output valid, output out_char, output end_of_text, input ready);
    modport sink (input valid, input out_char, input end_of_text, output ready);
endinterface

// ----- hdl/b64te_front.sv -----
module b64te_front
    import b64te_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64te_byte_if.sink  byte_in,
    input  logic        full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [CARRY_W-1:0] carry_reg;
    logic [CARRY_W-1:0] carry_next;
    logic [BYTE_W-1:0]  b;
    logic               fin;

    assign byte_in.ready = !full;
    assign push          = byte_in.valid && !full;
    assign b             = byte_in.data_byte;
    assign fin           = byte_in.is_final;

    always_comb
    begin
        push_cmd   = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        unique case (phase_reg)
            PHASE_SECOND:
            begin
                push_cmd.digit[0] = {carry_reg[1:0], b[7:4]};
                if (fin)
                begin
                    push_cmd.digit[1]  = {b[3:0], 2'b00};
                    push_cmd.pad[2]    = 1'b1;
                    push_cmd.last_slot = 2'd2;
                    push_cmd.eot       = 1'b1;
                    phase_next         = PHASE_FIRST;
                    carry_next         = '0;
                end
                else
                begin
                    phase_next = PHASE_THIRD;
                    carry_next = b[3:0];
                end
            end
            PHASE_THIRD:
            begin
                push_cmd.digit[0]  = {carry_reg, b[7:6]};
                push_cmd.digit[1]  = b[5:0];
                push_cmd.last_slot = 2'd1;
                push_cmd.eot       = fin;
                phase_next         = PHASE_FIRST;
                carry_next         = '0;
            end
            default:
            begin
                push_cmd.digit[0] = b[7:2];
                if (fin)
                begin
                    push_cmd.digit[1]  = {b[1:0], 4'b0000};
                    push_cmd.pad[2]    = 1'b1;
                    push_cmd.pad[3]    = 1'b1;
                    push_cmd.last_slot = 2'd3;
                    push_cmd.eot       = 1'b1;
                    phase_next         = PHASE_FIRST;
                    carry_next         = '0;
                end
                else
                begin
                    phase_next = PHASE_SECOND;
                    carry_next = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            carry_reg <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

// ----- hdl/b64te_queue.sv -----
module b64te_queue
    import b64te_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(QUEUE_DEPTH);

    cmd_t               entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full       = (count_reg == MAX_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= MAX_COUNT)
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("request pushed into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ----- hdl/b64te_back.sv -----
module b64te_back
    import b64te_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  cmd_t         head_cmd,
    output logic         pop,
    b64te_char_if.source char_out
);

    logic [SLOT_W-1:0] slot_reg;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_eot_reg;
    logic              load;
    logic              last;
    logic [CHAR_W-1:0] char_next;

    assign load = head_valid && (!out_valid_reg || char_out.ready);
    assign last = (slot_reg == head_cmd.last_slot);
    assign pop  = load && last;

    assign char_next = head_cmd.pad[slot_reg] ? PAD_CHAR
                                              : digit_char(head_cmd.digit[slot_reg]);

    assign char_out.valid       = out_valid_reg;
    assign char_out.out_char    = out_char_reg;
    assign char_out.end_of_text = out_eot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                slot_reg      <= last ? '0 : slot_reg + 1'b1;
            end
            else if (char_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_next;
            out_eot_reg  <= head_cmd.eot && last;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> slot_reg <= head_cmd.last_slot)
        else $error("slot beyond last character of request");

    assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> slot_reg == '0)
        else $error("slot not at start while queue is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && slot_reg != '0 && !pop) |=> head_valid)
        else $error("partly sent request left the queue");

endmodule

// ----- hdl/base64_text_encoder.sv -----
// Base64 stream encoder with the alphabet A-Z, a-z, 0-9, '.', '_' and pad '-'. Bytes arrive
// on byte_in, one per request, with is_final on the last byte of a message; characters leave
// on char_out, one per request, with end_of_text on the last character of the message. The
// input side takes a byte every cycle while its two-entry queue has room, and the output
// register sends one character per cycle while char_out is ready, so a byte gives one
// character at the first and second place of a group, two at the third, and up to four for
// the final byte (flush and pads); three bytes give four characters in steady flow. Empty
// messages give no output; no clearing runs after reset.
module base64_text_encoder
    import b64te_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    b64te_byte_if.sink   byte_in,
    b64te_char_if.source char_out
);

    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    b64te_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    b64te_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    b64te_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .char_out   (char_out)
    );

endmodule
